FILE: rtl/core/json_string_escaper_macros.svh
// Assertion macros shared by the JSON string escaper RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef JSON_STRING_ESCAPER_MACROS_SVH
`define JSON_STRING_ESCAPER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define JSE_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define JSE_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/jse_pkg.sv
// Shared types and character constants for the JSON string escaper.
// No dependencies; imported by every module of the block.
package jse_pkg;

	typedef enum logic [1:0] {
		KIND_PASS,
		KIND_SHORT,
		KIND_HEX
	} kind_t;

	// One classified code point: pass byte or escape letter in chr, low half in low16.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  chr;
		logic [15:0] low16;
	} cls_t;

	localparam int unsigned CP_W = 21;

	localparam logic [CP_W-1:0] CP_CTRL_MAX  = 21'h00001F;
	localparam logic [CP_W-1:0] CP_ASCII_END = 21'h000080;
	localparam logic [CP_W-1:0] CP_QUOTE     = 21'h000022;
	localparam logic [CP_W-1:0] CP_BSLASH    = 21'h00005C;
	localparam logic [CP_W-1:0] CP_LF        = 21'h00000A;
	localparam logic [CP_W-1:0] CP_CR        = 21'h00000D;
	localparam logic [CP_W-1:0] CP_TAB       = 21'h000009;
	localparam logic [CP_W-1:0] CP_BS        = 21'h000008;
	localparam logic [CP_W-1:0] CP_FF        = 21'h00000C;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_A_OFS  = 8'h57; // 'a' minus ten

endpackage

FILE: rtl/core/json_string_escaper.sv
// Top level of the JSON string escaper: front end, request queue, back end.
// Depends on jse_pkg, jse_front, jse_queue, jse_back.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-------------------------
//  input     | cp_valid / cp_ready   | code_point[20:0]
//  output    | esc_valid / esc_ready | out_byte[7:0], last_of_run
//
// Each request yields one byte (0x20 to 0x7F other than quote and backslash),
// two (backslash and a letter) or six (backslash, 'u', four hex digits); the back
// end emits one byte a cycle while the output port accepts, which sets the rate.
// Reset (arst_n low) empties the front register, the queue and the back end.
// Either side may stall; the queue of QUEUE_DEPTH requests lets the front keep
// accepting while the back end is busy with a long escape.
module json_string_escaper
	import jse_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4 // power of two, 2 or more
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [CP_W-1:0] code_point,
	input  logic            cp_valid,
	output logic            cp_ready,
	output logic [7:0]      out_byte,
	output logic            last_of_run,
	output logic            esc_valid,
	input  logic            esc_ready
);

	// Classified request from the front end into the queue.
	cls_t fq_data;
	logic fq_valid;
	logic fq_ready;

	// Head of the queue into the back end.
	cls_t qb_data;
	logic qb_valid;
	logic qb_ready;

	// Classify each code point and register it.
	jse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_point (code_point),
		.cp_valid   (cp_valid),
		.cp_ready   (cp_ready),
		.item       (fq_data),
		.item_valid (fq_valid),
		.item_ready (fq_ready)
	);

	// Buffer requests so the front does not wait on long escapes.
	jse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (fq_data),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.pop_data   (qb_data),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready)
	);

	// Expand each request into bytes behind a registered output.
	jse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (qb_data),
		.item_valid  (qb_valid),
		.item_ready  (qb_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.esc_valid   (esc_valid),
		.esc_ready   (esc_ready)
	);

endmodule

FILE: rtl/core/jse_front.sv
// Front end: accepts code points and classifies them into escape kinds.
// Depends on jse_pkg.
module jse_front
	import jse_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic [CP_W-1:0] code_point,
	input  logic            cp_valid,
	output logic            cp_ready,
	output cls_t            item,
	output logic            item_valid,
	input  logic            item_ready
);

	cls_t cls;
	cls_t item_s1;
	logic valid_s1;

	always_comb begin
		logic pass;
		pass = (code_point > CP_CTRL_MAX) && (code_point < CP_ASCII_END)
			&& (code_point != CP_QUOTE) && (code_point != CP_BSLASH);
		cls.low16 = code_point[15:0];
		cls.chr = 8'h00;
		cls.kind = KIND_HEX;
		if (pass) begin
			cls.kind = KIND_PASS;
			cls.chr = code_point[7:0];
		end else begin
			cls.kind = KIND_SHORT;
			case (code_point)
				CP_QUOTE:  cls.chr = CH_QUOTE;
				CP_BSLASH: cls.chr = CH_BSLASH;
				CP_LF:     cls.chr = CH_N;
				CP_CR:     cls.chr = CH_R;
				CP_TAB:    cls.chr = CH_T;
				CP_BS:     cls.chr = CH_B;
				CP_FF:     cls.chr = CH_F;
				default:   cls.kind = KIND_HEX;
			endcase
		end
	end

	assign cp_ready = !valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cp_ready) begin
			valid_s1 <= cp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cp_ready && cp_valid) begin
			item_s1 <= cls;
		end
	end

	assign item = item_s1;
	assign item_valid = valid_s1;

endmodule

FILE: rtl/core/jse_queue.sv
// Short queue of classified requests between front and back ends.
// Depends on jse_pkg and json_string_escaper_macros.svh.
`include "json_string_escaper_macros.svh"
module jse_queue
	import jse_pkg::*;
#(
	parameter int unsigned DEPTH = 4 // power of two, 2 or more
) (
	input  logic clk,
	input  logic arst_n,
	input  cls_t push_data,
	input  logic push_valid,
	output logic push_ready,
	output cls_t pop_data,
	output logic pop_valid,
	input  logic pop_ready
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cls_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push = push_valid && push_ready;
	assign pop  = pop_valid && pop_ready;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`JSE_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "queue count above depth")
	`JSE_ASSERT_NEXT(a_count_track, push && !pop, count_q == $past(count_q) + 1'b1, "queue count lost a push")

endmodule

FILE: rtl/core/jse_back.sv
// Back end: expands a request into escaped bytes, one per cycle unless stalled.
// Depends on jse_pkg and json_string_escaper_macros.svh.
`include "json_string_escaper_macros.svh"
module jse_back
	import jse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cls_t       item,
	input  logic       item_valid,
	output logic       item_ready,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	output logic       esc_valid,
	input  logic       esc_ready
);

	localparam logic [2:0] LAST_PASS  = 3'd0;
	localparam logic [2:0] LAST_SHORT = 3'd1;
	localparam logic [2:0] LAST_HEX   = 3'd5;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return CH_ZERO + {4'h0, nib};
		end
		return CH_A_OFS + {4'h0, nib};
	endfunction

	function automatic logic [2:0] last_idx(input kind_t kind);
		case (kind)
			KIND_PASS:  return LAST_PASS;
			KIND_SHORT: return LAST_SHORT;
			default:    return LAST_HEX;
		endcase
	endfunction

	cls_t       cur_q;
	logic [2:0] idx_q;
	logic       busy_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic       out_valid_q;
	logic       adv;
	logic       at_last;
	logic [7:0] next_byte;

	assign adv     = busy_q && (!out_valid_q || esc_ready);
	assign at_last = (idx_q == last_idx(cur_q.kind));
	assign item_ready = !busy_q || (adv && at_last);

	always_comb begin
		case (idx_q)
			3'd0:    next_byte = (cur_q.kind == KIND_PASS) ? cur_q.chr : CH_BSLASH;
			3'd1:    next_byte = (cur_q.kind == KIND_SHORT) ? cur_q.chr : CH_U;
			3'd2:    next_byte = hex_char(cur_q.low16[15:12]);
			3'd3:    next_byte = hex_char(cur_q.low16[11:8]);
			3'd4:    next_byte = hex_char(cur_q.low16[7:4]);
			default: next_byte = hex_char(cur_q.low16[3:0]);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || esc_ready) begin
				out_valid_q <= busy_q;
			end
			if (item_valid && item_ready) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (adv) begin
				if (at_last) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			cur_q <= item;
		end
		if (adv) begin
			out_byte_q <= next_byte;
			last_q     <= at_last;
		end
	end

	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;
	assign esc_valid   = out_valid_q;

	`JSE_ASSERT_SAME(a_idx_bound, busy_q, idx_q <= last_idx(cur_q.kind), "byte index past end of escape")
	`JSE_ASSERT_NEXT(a_pass_single, adv && (cur_q.kind == KIND_PASS), last_q, "pass byte not marked last")

endmodule

FILE: dv/tb_json_string_escaper.sv
`timescale 1ns / 100ps
// Self-checking testbench for json_string_escaper: code point requests in, escaped bytes out.
// Depends on jse_pkg and the RTL of the block; predicts every byte and compares in order.

module tb_json_string_escaper;
	import jse_pkg::*;

	// One expected byte of an escape and whether it closes the run.
	typedef struct packed {
		logic [7:0] chr;
		logic       last;
	} esc_byte_t;

	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned SETTLE_CYCLES = 20;
	localparam int unsigned ITEMS_PER_PHASE = 39;

	logic            clk;
	logic            arst_n;
	logic [CP_W-1:0] code_point = '0;
	logic            cp_valid = 1'b0;
	logic            cp_ready;
	logic [7:0]      out_byte;
	logic            last_of_run;
	logic            esc_valid;
	logic            esc_ready = 1'b0;

	logic [CP_W-1:0] cp_pending_q[$];
	esc_byte_t       escaped_bytes_q[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatch_count = 0;
	int unsigned hold_trigger = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;

	json_string_escaper u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_point (code_point),
		.cp_valid   (cp_valid),
		.cp_ready   (cp_ready),
		.out_byte   (out_byte),
		.last_of_run(last_of_run),
		.esc_valid  (esc_valid),
		.esc_ready  (esc_ready)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Lower-case hex digit for one nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return CH_ZERO + 8'(nib);
		end
		return CH_A_OFS + 8'(nib);
	endfunction

	// Append the escaped bytes of one accepted request to the expected stream.
	function automatic void escape_code_point(input logic [CP_W-1:0] cp);
		logic [7:0]  letter;
		logic [15:0] low;
		letter = 8'h00;
		low = cp[15:0];
		if (cp > CP_CTRL_MAX && cp < CP_ASCII_END && cp != CP_QUOTE && cp != CP_BSLASH) begin
			escaped_bytes_q.push_back('{chr: cp[7:0], last: 1'b1});
			return;
		end
		case (cp)
			CP_QUOTE:  letter = CH_QUOTE;
			CP_BSLASH: letter = CH_BSLASH;
			CP_LF:     letter = CH_N;
			CP_CR:     letter = CH_R;
			CP_TAB:    letter = CH_T;
			CP_BS:     letter = CH_B;
			CP_FF:     letter = CH_F;
			default:   letter = 8'h00;
		endcase
		escaped_bytes_q.push_back('{chr: CH_BSLASH, last: 1'b0});
		if (letter != 8'h00) begin
			escaped_bytes_q.push_back('{chr: letter, last: 1'b1});
		end else begin
			// Anything above the BMP keeps only its low half, no surrogate pair.
			escaped_bytes_q.push_back('{chr: CH_U, last: 1'b0});
			escaped_bytes_q.push_back('{chr: hex_char(low[15:12]), last: 1'b0});
			escaped_bytes_q.push_back('{chr: hex_char(low[11:8]), last: 1'b0});
			escaped_bytes_q.push_back('{chr: hex_char(low[7:4]), last: 1'b0});
			escaped_bytes_q.push_back('{chr: hex_char(low[3:0]), last: 1'b1});
		end
	endfunction

	// Mix of classes so that every escape form comes up often, plus full-range noise.
	function automatic logic [CP_W-1:0] random_code_point();
		logic [CP_W-1:0] short_cps[7];
		int unsigned pick;
		short_cps = '{CP_QUOTE, CP_BSLASH, CP_LF, CP_CR, CP_TAB, CP_BS, CP_FF};
		pick = $urandom_range(99);
		if (pick < 35) begin
			return CP_W'($urandom_range(32'h20, 32'h7F));
		end else if (pick < 50) begin
			return short_cps[$urandom_range(6)];
		end else if (pick < 62) begin
			return CP_W'($urandom_range(32'h00, 32'h1F));
		end else if (pick < 78) begin
			return CP_W'($urandom_range(32'h80, 32'hFFFF));
		end
		return CP_W'($urandom);
	endfunction

	task automatic queue_random(input int unsigned count);
		repeat (count) cp_pending_q.push_back(random_code_point());
	endtask

	task automatic drain();
		@(negedge clk);
		while (cp_pending_q.size() != 0 || cp_valid || escaped_bytes_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Driver: present the next pending request, or idle at the configured rate.
	// Predict a request at the edge where it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_valid   <= 1'b0;
			code_point <= '0;
		end else if (!cp_valid || cp_ready) begin
			if (cp_valid) begin
				escape_code_point(code_point);
			end
			if (cp_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				code_point <= cp_pending_q.pop_front();
				cp_valid   <= 1'b1;
			end else begin
				cp_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off: restart the count whenever the stimulus bumps the trigger.
	always @(posedge clk) begin
		if (hold_trigger != hold_seen) begin
			hold_seen <= hold_trigger;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: compare every accepted byte with the oldest expected one, then pick ready.
	always @(posedge clk or negedge arst_n) begin
		esc_byte_t want;
		if (!arst_n) begin
			esc_ready <= 1'b0;
		end else begin
			if (esc_valid && esc_ready) begin
				if (escaped_bytes_q.size() == 0) begin
					$error("unexpected byte: out_byte=%h last_of_run=%b", out_byte, last_of_run);
					mismatch_count++;
				end else begin
					want = escaped_bytes_q.pop_front();
					if (out_byte !== want.chr) begin
						$error("out_byte: expected %h, actual %h", want.chr, out_byte);
						mismatch_count++;
					end
					if (last_of_run !== want.last) begin
						$error("last_of_run: expected %b, actual %b", want.last, last_of_run);
						mismatch_count++;
					end
				end
			end
			esc_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#2_400_000;
		$display("simulation failed");
		$finish;
	end

	// Stimulus: directed corners first, then random requests under each idling pattern.
	initial begin
		logic [CP_W-1:0] corners[$];

		// drain() holds until every pending request is accepted and every byte has come back.
		// Flow-control knobs only change at the falling edge, away from the sampling edge.
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		corners = '{
			21'h000000, 21'h000007, 21'h00001F, 21'h000020, 21'h000041, 21'h00007E,
			21'h00007F, 21'h000080, 21'h0000A0, CP_QUOTE, CP_BSLASH, CP_LF, CP_CR,
			CP_TAB, CP_BS, CP_FF, 21'h00D800, 21'h00DFFF, 21'h00FFFF, 21'h010000,
			21'h10FFFF, 21'h110000, 21'h1FFFFF, 21'h1ABCDE, 21'h0F1234
		};
		foreach (corners[i]) begin
			cp_pending_q.push_back(corners[i]);
		end
		drain();

		// No idling on either side.
		queue_random(ITEMS_PER_PHASE);
		drain();

		// Sender idles most cycles.
		send_idle_pct = 61;
		recv_stall_pct = 0;
		queue_random(ITEMS_PER_PHASE);
		drain();

		// Receiver stalls most cycles; long escapes back up into the queue.
		send_idle_pct = 0;
		recv_stall_pct = 61;
		queue_random(ITEMS_PER_PHASE);
		drain();

		// Light idling on both sides.
		send_idle_pct = 8;
		recv_stall_pct = 8;
		queue_random(ITEMS_PER_PHASE);
		drain();

		// Receiver holds off for a long stretch while the sender keeps offering,
		// so the request queue fills and cp_ready drops.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_trigger = hold_trigger + 1;
		queue_random(ITEMS_PER_PHASE);
		drain();

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && escaped_bytes_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

FILE: json_string_escaper.f
+incdir+rtl/core
rtl/core/jse_pkg.sv
rtl/core/jse_front.sv
rtl/core/jse_queue.sv
rtl/core/jse_back.sv
rtl/core/json_string_escaper.sv
dv/tb_json_string_escaper.sv
